// ===== sv/chip8c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CHIP-8 core package
// Shared types, codes, the hex font table and small decode helpers.
// ----------------------------------------------------------------------------
package chip8c_pkg;

    localparam logic [11:0] PC_START      = 12'h200;
    localparam int          FONT_BYTES    = 80;
    localparam int          SCREEN_PIXELS = 2048;

    localparam logic [1:0] FUNC_WR   = 2'd0;
    localparam logic [1:0] FUNC_RD   = 2'd1;
    localparam logic [1:0] FUNC_PIX  = 2'd2;
    localparam logic [1:0] FUNC_EXEC = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_WAIT  = 2'd1;
    localparam logic [1:0] STAT_BADOP = 2'd2;
    localparam logic [1:0] STAT_STACK = 2'd3;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_CMD, ST_RDW, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5,
        ST_EXEC, ST_FLAG, ST_DROW, ST_DBYTE, ST_DPIX, ST_DXOR, ST_BCD,
        ST_STO_RD, ST_STO_WR, ST_LD_RD, ST_LD_WR, ST_IADV, ST_FIN
    } t_state;

    typedef enum logic [3:0] {
        ALU_PASS, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_RSUB,
        ALU_SHR, ALU_SHL
    } t_alu_op;

    typedef struct packed {
        logic       we;
        logic [3:0] addr;
        logic [7:0] data;
    } t_rf_wr;

    function automatic logic [7:0] font_byte(input logic [6:0] a);
        if (32'(a) < FONT_BYTES) return FONT[a];
        return 8'h00;
    endfunction

    // ALU operation for the 8XYn group.
    function automatic t_alu_op alu_op_of(input logic [3:0] n);
        t_alu_op op;
        case (n)
            4'h1:    op = ALU_OR;
            4'h2:    op = ALU_AND;
            4'h3:    op = ALU_XOR;
            4'h4:    op = ALU_ADD;
            4'h5:    op = ALU_SUB;
            4'h6:    op = ALU_SHR;
            4'h7:    op = ALU_RSUB;
            4'hE:    op = ALU_SHL;
            default: op = ALU_PASS;
        endcase
        return op;
    endfunction

    function automatic logic sub_valid(input logic [3:0] n);
        return (n <= 4'h7) || (n == 4'hE);
    endfunction

    function automatic logic sub_sets_flag(input logic [3:0] n);
        return ((n >= 4'h4) && (n <= 4'h7)) || (n == 4'hE);
    endfunction

    // Bit 4 is set when a key is pressed, bits 3:0 give the lowest one.
    function automatic logic [4:0] lowest_key(input logic [15:0] k);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 15; i >= 0; i--) begin
            if (k[i]) r = {1'b1, 4'(i)};
        end
        return r;
    endfunction

    // Decimal digit sel (0 hundreds, 1 tens, 2 ones) of an 8-bit value.
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [1:0]  h;
        logic [7:0]  rem;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [7:0]  o;
        h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        rem  = v - 8'(h) * 8'd100;
        prod = 15'(rem) * 15'd205;
        t    = prod[14:11];
        o    = rem - 8'(t) * 8'd10;
        case (sel)
            2'd0:    return {6'd0, h};
            2'd1:    return {4'd0, t};
            default: return o;
        endcase
    endfunction

endpackage

// ===== sv/chip8_instruction_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CHIP-8 instruction core
// Memory, screen and register state with a sequenced instruction executor.
// ----------------------------------------------------------------------------
// After reset the core sweeps its program memory and screen, one entry per
// cycle, for the larger of MEMORY_BYTES and 2048 entries, loading the font and
// clearing everything else; no request is taken meanwhile. Each request is
// then handled alone. A write passes CMD and FIN, a memory or pixel read also
// RDW, as the single-port RAMs register read data. An instruction reads its
// opcode and operands in F1 to F5 through the one RAM port and the one
// register file read port; FX33 adds the BCD state, FX55 and FX65 a read and
// a write state per register plus IADV, and DXYN a DROW and DBYTE per row, a
// DPIX per sprite bit and a DXOR per lit bit. One result is produced per
// request and held until taken; the timers step once per executed instruction.
module chip8_instruction_core #(
    parameter int MEMORY_BYTES = 4096,
    parameter int STACK_DEPTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address[11:0], write_data[19:12], key_state[35:20], random_byte[43:36]
    input  logic [47:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], program_counter[19:8], index_value[31:20], status[33:32],
    // drew[34], sound_on[35], delay_value[43:36]
    output logic [47:0] m_axis_tdata
);
    import chip8c_pkg::*;

    localparam int AW    = $clog2(MEMORY_BYTES);
    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int SIW   = $clog2(STACK_DEPTH);
    localparam int CLR_N = (MEMORY_BYTES > SCREEN_PIXELS) ? MEMORY_BYTES : SCREEN_PIXELS;
    localparam int CLW   = $clog2(CLR_N);

    function automatic logic [AW-1:0] mem_wrap(input logic [12:0] v);
        logic [12:0] t;
        t = v;
        for (int k = 0; k < 4; k++) begin
            if (t >= 13'(MEMORY_BYTES)) t = t - 13'(MEMORY_BYTES);
        end
        return t[AW-1:0];
    endfunction

    t_state r_state, n_state;

    // Architectural state
    logic [11:0]     r_pc, n_pc, r_index, n_index;
    logic [7:0]      r_delay, n_delay, r_sound, n_sound;
    logic [SPW-1:0]  r_sp, n_sp;
    logic [11:0]     r_stack [STACK_DEPTH];
    logic            stk_we;
    logic [CLW-1:0]  r_clr, n_clr;
    logic            r_ovalid, n_ovalid;

    // Request and working registers
    logic [1:0]  r_func, n_func;
    logic [11:0] r_addr, n_addr;
    logic [7:0]  r_wdata, n_wdata, r_rnd, n_rnd;
    logic [15:0] r_keys, n_keys;
    logic [15:0] r_op, n_op;
    logic [7:0]  r_vx, n_vx, r_vy, n_vy, r_v0, n_v0;
    logic [1:0]  r_status, n_status;
    logic        r_drew, n_drew, r_hit, n_hit, r_flag, n_flag;
    logic [7:0]  r_rd, n_rd, r_sprite, n_sprite;
    logic [3:0]  r_row, n_row, r_i, n_i;
    logic [2:0]  r_col, n_col;

    // Result register
    logic [7:0]  r_o_rd, n_o_rd, r_o_delay, n_o_delay;
    logic [11:0] r_o_pc, n_o_pc, r_o_index, n_o_index;
    logic [1:0]  r_o_status, n_o_status;
    logic        r_o_drew, n_o_drew, r_o_sound, n_o_sound;

    // Memory ports
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wd, ram_q;
    logic          scr_we, scr_wd, scr_q;
    logic [10:0]   scr_addr;
    t_rf_wr        rf_wr;
    logic [3:0]    rf_raddr;
    logic [7:0]    rf_q;

    t_alu_op     alu_op;
    logic [11:0] alu_a, alu_b;
    logic [12:0] alu_res;
    logic        alu_flag;

    logic [3:0]     w_x, w_n;
    logic [7:0]     w_nn;
    logic [11:0]    w_nnn, w_next, w_skip;
    logic [SPW-1:0] w_sp_m1;
    logic [10:0]    w_pix;
    logic           w_bit, w_accept, w_out_free;
    logic [4:0]     w_key;
    logic [7:0]     w_dly, w_snd;

    assign w_x      = r_op[11:8];
    assign w_n      = r_op[3:0];
    assign w_nn     = r_op[7:0];
    assign w_nnn    = r_op[11:0];
    assign w_next   = r_pc + 12'd2;
    assign w_skip   = r_pc + 12'd4;
    assign w_sp_m1  = r_sp - SPW'(1);
    assign w_pix    = {r_vy[4:0] + 5'(r_row), r_vx[5:0] + 6'(r_col)};
    assign w_bit    = r_sprite[3'd7 - r_col];
    assign w_key    = lowest_key(r_keys);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_dly    = (r_func == FUNC_EXEC && r_delay != 8'd0) ? r_delay - 8'd1 : r_delay;
    assign w_snd    = (r_func == FUNC_EXEC && r_sound != 8'd0) ? r_sound - 8'd1 : r_sound;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_o_delay, r_o_sound, r_o_drew, r_o_status,
                            r_o_index, r_o_pc, r_o_rd};

    chip8c_ram #(.DEPTH(MEMORY_BYTES), .WIDTH(8)) u_prog (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr), .i_wdata(ram_wd), .o_rdata(ram_q)
    );

    chip8c_ram #(.DEPTH(SCREEN_PIXELS), .WIDTH(1)) u_screen (
        .i_clk(i_clk), .i_we(scr_we), .i_addr(scr_addr), .i_wdata(scr_wd), .o_rdata(scr_q)
    );

    chip8c_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(rf_wr), .i_raddr(rf_raddr), .o_rdata(rf_q)
    );

    chip8c_alu u_alu (
        .i_op(alu_op), .i_a(alu_a), .i_b(alu_b), .o_res(alu_res), .o_flag(alu_flag)
    );

    // ALU operand selection; address steps default to index plus counter.
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = r_index;
        alu_b  = 12'(r_i);
        case (r_state)
            ST_EXEC: begin
                case (r_op[15:12])
                    4'h7: begin
                        alu_a = 12'(r_vx);
                        alu_b = 12'(w_nn);
                    end
                    4'h8: begin
                        alu_op = alu_op_of(w_n);
                        alu_a  = 12'(r_vx);
                        alu_b  = 12'(r_vy);
                    end
                    4'hB: begin
                        alu_a = w_nnn;
                        alu_b = 12'(r_v0);
                    end
                    default: begin
                        alu_b = 12'(r_vx);
                    end
                endcase
            end
            ST_DROW: alu_b = 12'(r_row);
            ST_IADV: alu_b = 12'(w_x) + 12'd1;
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == CLW'(CLR_N - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (w_accept) n_state = ST_CMD;
            ST_CMD: begin
                if (r_func == FUNC_EXEC) n_state = ST_F1;
                else if (r_func == FUNC_WR) n_state = ST_FIN;
                else n_state = ST_RDW;
            end
            ST_RDW: n_state = ST_FIN;
            ST_F1:  n_state = ST_F2;
            ST_F2:  n_state = ST_F3;
            ST_F3:  n_state = ST_F4;
            ST_F4:  n_state = ST_F5;
            ST_F5:  n_state = ST_EXEC;
            ST_EXEC: begin
                n_state = ST_FIN;
                if (r_op[15:12] == 4'h8 && sub_sets_flag(w_n)) n_state = ST_FLAG;
                else if (r_op[15:12] == 4'hD) n_state = ST_DROW;
                else if (r_op[15:12] == 4'hF) begin
                    if (w_nn == 8'h33) n_state = ST_BCD;
                    else if (w_nn == 8'h55) n_state = ST_STO_RD;
                    else if (w_nn == 8'h65) n_state = ST_LD_RD;
                end
            end
            ST_FLAG:  n_state = ST_FIN;
            ST_DROW:  n_state = (r_row == w_n) ? ST_FIN : ST_DBYTE;
            ST_DBYTE: n_state = ST_DPIX;
            ST_DPIX: begin
                if (w_bit) n_state = ST_DXOR;
                else if (r_col == 3'd7) n_state = ST_DROW;
            end
            ST_DXOR:   n_state = (r_col == 3'd7) ? ST_DROW : ST_DPIX;
            ST_BCD:    if (r_i == 4'd2) n_state = ST_FIN;
            ST_STO_RD: n_state = ST_STO_WR;
            ST_STO_WR: n_state = (r_i == w_x) ? ST_IADV : ST_STO_RD;
            ST_LD_RD:  n_state = ST_LD_WR;
            ST_LD_WR:  n_state = (r_i == w_x) ? ST_IADV : ST_LD_RD;
            ST_IADV:   n_state = ST_FIN;
            ST_FIN:    if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_pc = r_pc;   n_index = r_index; n_delay = r_delay; n_sound = r_sound;
        n_sp = r_sp;   n_clr = r_clr;
        n_func = r_func; n_addr = r_addr; n_wdata = r_wdata; n_rnd = r_rnd;
        n_keys = r_keys; n_op = r_op; n_vx = r_vx; n_vy = r_vy; n_v0 = r_v0;
        n_status = r_status; n_drew = r_drew; n_hit = r_hit; n_flag = r_flag;
        n_rd = r_rd; n_sprite = r_sprite; n_row = r_row; n_i = r_i; n_col = r_col;
        n_o_rd = r_o_rd; n_o_pc = r_o_pc; n_o_index = r_o_index;
        n_o_status = r_o_status; n_o_drew = r_o_drew; n_o_sound = r_o_sound;
        n_o_delay = r_o_delay;
        n_ovalid = r_ovalid && !m_axis_tready;
        ram_we = 1'b0; ram_addr = mem_wrap({1'b0, r_pc}); ram_wd = 8'h00;
        scr_we = 1'b0; scr_addr = w_pix; scr_wd = 1'b0;
        rf_wr = '0; rf_raddr = r_i;
        stk_we = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                ram_we   = (32'(r_clr) < MEMORY_BYTES);
                ram_addr = r_clr[AW-1:0];
                ram_wd   = (32'(r_clr) < FONT_BYTES) ? font_byte(r_clr[6:0]) : 8'h00;
                scr_we   = (32'(r_clr) < SCREEN_PIXELS);
                scr_addr = r_clr[10:0];
                n_clr    = r_clr + CLW'(1);
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_func   = s_axis_tuser;
                    n_addr   = s_axis_tdata[11:0];
                    n_wdata  = s_axis_tdata[19:12];
                    n_keys   = s_axis_tdata[35:20];
                    n_rnd    = s_axis_tdata[43:36];
                    n_rd     = 8'h00;
                    n_status = STAT_OK;
                    n_drew   = 1'b0;
                end
            end
            ST_CMD: begin
                if (r_func != FUNC_EXEC) ram_addr = mem_wrap({1'b0, r_addr});
                ram_we   = (r_func == FUNC_WR);
                ram_wd   = r_wdata;
                scr_addr = r_addr[10:0];
            end
            ST_RDW: n_rd = (r_func == FUNC_RD) ? ram_q : {7'd0, scr_q};
            ST_F1: begin
                n_op[15:8] = ram_q;
                ram_addr   = mem_wrap({1'b0, r_pc} + 13'd1);
            end
            ST_F2: begin
                n_op[7:0] = ram_q;
                rf_raddr  = r_op[11:8];
            end
            ST_F3: begin
                n_vx     = rf_q;
                rf_raddr = r_op[7:4];
            end
            ST_F4: begin
                n_vy     = rf_q;
                rf_raddr = 4'd0;
            end
            ST_F5: n_v0 = rf_q;
            ST_EXEC: begin
                n_pc   = w_next;
                n_row  = 4'd0;
                n_col  = 3'd0;
                n_i    = 4'd0;
                n_hit  = 1'b0;
                n_flag = alu_flag;
                case (r_op[15:12])
                    4'h0: begin
                        if (r_op != 16'h00EE) n_status = STAT_BADOP;
                        else if (r_sp == '0) n_status = STAT_STACK;
                        else begin
                            n_sp = w_sp_m1;
                            n_pc = r_stack[w_sp_m1[SIW-1:0]];
                        end
                    end
                    4'h1: n_pc = w_nnn;
                    4'h2: begin
                        if (32'(r_sp) >= STACK_DEPTH) n_status = STAT_STACK;
                        else begin
                            stk_we = 1'b1;
                            n_sp   = r_sp + SPW'(1);
                            n_pc   = w_nnn;
                        end
                    end
                    4'h3: n_pc = (r_vx == w_nn) ? w_skip : w_next;
                    4'h4: n_pc = (r_vx != w_nn) ? w_skip : w_next;
                    4'h5: n_pc = (r_vx == r_vy) ? w_skip : w_next;
                    4'h9: n_pc = (r_vx != r_vy) ? w_skip : w_next;
                    4'h6: rf_wr = '{we: 1'b1, addr: w_x, data: w_nn};
                    4'h7: rf_wr = '{we: 1'b1, addr: w_x, data: alu_res[7:0]};
                    4'h8: begin
                        if (sub_valid(w_n)) rf_wr = '{we: 1'b1, addr: w_x, data: alu_res[7:0]};
                        else n_status = STAT_BADOP;
                    end
                    4'hA: n_index = w_nnn;
                    4'hB: n_pc = alu_res[11:0];
                    4'hC: rf_wr = '{we: 1'b1, addr: w_x, data: r_rnd & w_nn};
                    4'hD: n_drew = 1'b0;
                    4'hE: begin
                        if (w_nn == 8'h9E) n_pc = r_keys[r_vx[3:0]] ? w_skip : w_next;
                        else if (w_nn == 8'hA1) n_pc = r_keys[r_vx[3:0]] ? w_next : w_skip;
                        else n_status = STAT_BADOP;
                    end
                    default: begin
                        case (w_nn) inside
                            8'h07: rf_wr = '{we: 1'b1, addr: w_x, data: r_delay};
                            8'h0A: begin
                                if (w_key[4]) rf_wr = '{we: 1'b1, addr: w_x, data: 8'(w_key[3:0])};
                                else begin
                                    n_status = STAT_WAIT;
                                    n_pc     = r_pc;
                                end
                            end
                            8'h15: n_delay = r_vx;
                            8'h18: n_sound = r_vx;
                            8'h1E: n_index = alu_res[11:0];
                            8'h29: n_index = (12'(r_vx[3:0]) << 2) + 12'(r_vx[3:0]);
                            8'h33, 8'h55, 8'h65: ;
                            default: n_status = STAT_BADOP;
                        endcase
                    end
                endcase
            end
            ST_FLAG: rf_wr = '{we: 1'b1, addr: 4'hF, data: {7'd0, r_flag}};
            ST_DROW: begin
                ram_addr = mem_wrap(alu_res);
                if (r_row == w_n) rf_wr = '{we: 1'b1, addr: 4'hF, data: {7'd0, r_hit}};
            end
            ST_DBYTE: begin
                n_sprite = ram_q;
                n_col    = 3'd0;
            end
            ST_DPIX: begin
                if (!w_bit) begin
                    n_col = r_col + 3'd1;
                    if (r_col == 3'd7) n_row = r_row + 4'd1;
                end
            end
            ST_DXOR: begin
                // The pixel read last cycle is flipped; a lit one counts as a hit.
                scr_we = 1'b1;
                scr_wd = ~scr_q;
                n_hit  = r_hit | scr_q;
                n_drew = 1'b1;
                n_col  = r_col + 3'd1;
                if (r_col == 3'd7) n_row = r_row + 4'd1;
            end
            ST_BCD: begin
                ram_we   = 1'b1;
                ram_addr = mem_wrap(alu_res);
                ram_wd   = bcd_digit(r_vx, r_i[1:0]);
                n_i      = r_i + 4'd1;
            end
            ST_STO_RD: rf_raddr = r_i;
            ST_STO_WR: begin
                ram_we   = 1'b1;
                ram_addr = mem_wrap(alu_res);
                ram_wd   = rf_q;
                n_i      = r_i + 4'd1;
            end
            ST_LD_RD: ram_addr = mem_wrap(alu_res);
            ST_LD_WR: begin
                rf_wr = '{we: 1'b1, addr: r_i, data: ram_q};
                n_i   = r_i + 4'd1;
            end
            ST_IADV: n_index = alu_res[11:0];
            ST_FIN: begin
                if (w_out_free) begin
                    n_delay    = w_dly;
                    n_sound    = w_snd;
                    n_ovalid   = 1'b1;
                    n_o_rd     = r_rd;
                    n_o_pc     = r_pc;
                    n_o_index  = r_index;
                    n_o_status = r_status;
                    n_o_drew   = r_drew;
                    n_o_sound  = (w_snd != 8'd0);
                    n_o_delay  = w_dly;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_pc     <= PC_START;
            r_index  <= '0;
            r_delay  <= '0;
            r_sound  <= '0;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pc     <= n_pc;
            r_index  <= n_index;
            r_delay  <= n_delay;
            r_sound  <= n_sound;
            r_sp     <= n_sp;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[r_sp[SIW-1:0]] <= w_next;
        end
        r_func <= n_func;  r_addr <= n_addr;  r_wdata <= n_wdata; r_rnd <= n_rnd;
        r_keys <= n_keys;  r_op <= n_op;      r_vx <= n_vx;       r_vy <= n_vy;
        r_v0 <= n_v0;      r_status <= n_status; r_drew <= n_drew; r_hit <= n_hit;
        r_flag <= n_flag;  r_rd <= n_rd;      r_sprite <= n_sprite;
        r_row <= n_row;    r_i <= n_i;        r_col <= n_col;
        r_o_rd <= n_o_rd;  r_o_pc <= n_o_pc;  r_o_index <= n_o_index;
        r_o_status <= n_o_status; r_o_drew <= n_o_drew;
        r_o_sound <= n_o_sound;   r_o_delay <= n_o_delay;
    end
endmodule

// ===== sv/chip8c_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CHIP-8 single-port RAM
// One address per cycle, written and read together; registered read data.
// ----------------------------------------------------------------------------
module chip8c_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;
endmodule

// ===== sv/chip8c_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CHIP-8 register file
// Sixteen byte registers, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module chip8c_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chip8c_pkg::t_rf_wr i_wr,
    input  logic [3:0]        i_raddr,
    output logic [7:0]        o_rdata
);
    import chip8c_pkg::*;

    logic [7:0]  r_mem [16];
    logic [15:0] r_valid;
    logic [7:0]  r_q;

    // A register never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= r_valid[i_raddr] ? r_mem[i_raddr] : 8'h00;
    end

    assign o_rdata = r_q;
endmodule

// ===== sv/chip8c_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CHIP-8 shared ALU
// Logic, add, subtract and shift with the VF flag; also forms addresses.
// ----------------------------------------------------------------------------
module chip8c_alu (
    input  chip8c_pkg::t_alu_op i_op,
    input  logic [11:0]         i_a,
    input  logic [11:0]         i_b,
    output logic [12:0]         o_res,
    output logic                o_flag
);
    import chip8c_pkg::*;

    logic [12:0] w_sum;
    assign w_sum = {1'b0, i_a} + {1'b0, i_b};

    always_comb begin
        o_res  = {1'b0, i_b};
        o_flag = 1'b0;
        unique case (i_op)
            ALU_PASS: o_res = {1'b0, i_b};
            ALU_OR:   o_res = {1'b0, i_a | i_b};
            ALU_AND:  o_res = {1'b0, i_a & i_b};
            ALU_XOR:  o_res = {1'b0, i_a ^ i_b};
            ALU_ADD: begin
                // Carry out of the low byte for byte operands.
                o_res  = w_sum;
                o_flag = w_sum[8];
            end
            ALU_SUB: begin
                o_res  = {1'b0, i_a - i_b};
                o_flag = (i_a >= i_b);
            end
            ALU_RSUB: begin
                o_res  = {1'b0, i_b - i_a};
                o_flag = (i_b >= i_a);
            end
            ALU_SHR: begin
                o_res  = {2'b00, i_a[11:1]};
                o_flag = i_a[0];
            end
            ALU_SHL: begin
                o_res  = {i_a, 1'b0};
                o_flag = i_a[7];
            end
            default: o_res = {1'b0, i_b};
        endcase
    end
endmodule

// ===== sim/tb_chip8_instruction_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CHIP-8 instruction core testbench
// Drives memory, pixel and execute requests into the core, keeps its own
// model of the machine state, and checks every result field against it.
// ----------------------------------------------------------------------------
module tb_chip8_instruction_core;
    import chip8c_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [7:0]  delay_value;
        logic        sound_on;
        logic        drew;
        logic [1:0]  status;
        logic [11:0] index_value;
        logic [11:0] program_counter;
        logic [7:0]  read_data;
    } t_core_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // address[11:0], write_data[19:12], key_state[35:20], random_byte[43:36]
    logic [47:0] s_axis_tdata = '0;
    // func[1:0]
    logic [1:0]  s_axis_tuser = FUNC_WR;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // read_data[7:0], program_counter[19:8], index_value[31:20], status[33:32],
    // drew[34], sound_on[35], delay_value[43:36]
    logic [47:0] m_axis_tdata;

    chip8_instruction_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Shadow machine state.
    logic [7:0]  mem_shadow [4096];
    logic [7:0]  vreg [16];
    logic [11:0] stack_shadow [16];
    int          stack_depth_now;
    logic [11:0] index_shadow;
    logic [11:0] pc_shadow;
    logic [7:0]  delay_shadow;
    logic [7:0]  sound_shadow;
    bit          screen_shadow [2048];

    t_core_result pending_results [$];
    int  error_count = 0;
    int  request_count = 0;
    int  exec_count = 0;
    int  draw_count = 0;
    int  rx_hold = 0;
    int  rx_burst = 0;
    bit  no_idle = 1'b0;
    int  quiet_cycles = 0;

    task automatic execute_instruction(input logic [15:0] keys, input logic [7:0] rnd,
                                       output logic [1:0] st, output logic drew);
        logic [15:0] op;
        logic [3:0]  x, y;
        logic [7:0]  nn, vx, vy, row;
        logic [11:0] nnn, nxt, skp;
        logic [8:0]  res;
        logic        flag;
        logic [4:0]  py;
        logic [5:0]  px;
        op  = {mem_shadow[pc_shadow], mem_shadow[pc_shadow + 12'd1]};
        x   = op[11:8];
        y   = op[7:4];
        nn  = op[7:0];
        nnn = op[11:0];
        vx  = vreg[x];
        vy  = vreg[y];
        nxt = pc_shadow + 12'd2;
        skp = pc_shadow + 12'd4;
        st  = STAT_OK;
        drew = 1'b0;
        case (op[15:12])
            4'h0: begin
                if (op == 16'h00EE) begin
                    if (stack_depth_now == 0) begin
                        st = STAT_STACK;
                        pc_shadow = nxt;
                    end else begin
                        stack_depth_now--;
                        pc_shadow = stack_shadow[stack_depth_now];
                    end
                end else begin
                    st = STAT_BADOP;
                    pc_shadow = nxt;
                end
            end
            4'h1: pc_shadow = nnn;
            4'h2: begin
                if (stack_depth_now >= 16) begin
                    st = STAT_STACK;
                    pc_shadow = nxt;
                end else begin
                    stack_shadow[stack_depth_now] = nxt;
                    stack_depth_now++;
                    pc_shadow = nnn;
                end
            end
            4'h3: pc_shadow = (vx == nn) ? skp : nxt;
            4'h4: pc_shadow = (vx != nn) ? skp : nxt;
            4'h5: pc_shadow = (vx == vy) ? skp : nxt;
            4'h6: begin vreg[x] = nn; pc_shadow = nxt; end
            4'h7: begin vreg[x] = vx + nn; pc_shadow = nxt; end
            4'h8: begin
                flag = 1'b0;
                res  = {1'b0, vx};
                case (op[3:0])
                    4'h0: res = {1'b0, vy};
                    4'h1: res = {1'b0, vx | vy};
                    4'h2: res = {1'b0, vx & vy};
                    4'h3: res = {1'b0, vx ^ vy};
                    4'h4: begin res = {1'b0, vx} + {1'b0, vy}; flag = res[8]; end
                    4'h5: begin res = {1'b0, vx} - {1'b0, vy}; flag = (vx >= vy); end
                    4'h6: begin res = {1'b0, vx >> 1}; flag = vx[0]; end
                    4'h7: begin res = {1'b0, vy} - {1'b0, vx}; flag = (vy >= vx); end
                    4'hE: begin res = {1'b0, vx[6:0], 1'b0}; flag = vx[7]; end
                    default: st = STAT_BADOP;
                endcase
                if (st == STAT_OK) begin
                    vreg[x] = res[7:0];
                    // The flag is written last, so it wins when X is F.
                    if (op[3:0] >= 4'h4 && (op[3:0] <= 4'h7 || op[3:0] == 4'hE))
                        vreg[15] = {7'd0, flag};
                end
                pc_shadow = nxt;
            end
            4'h9: pc_shadow = (vx != vy) ? skp : nxt;
            4'hA: begin index_shadow = nnn; pc_shadow = nxt; end
            4'hB: pc_shadow = nnn + {4'd0, vreg[0]};
            4'hC: begin vreg[x] = rnd & nn; pc_shadow = nxt; end
            4'hD: begin
                flag = 1'b0;
                for (int r = 0; r < op[3:0]; r++) begin
                    row = mem_shadow[index_shadow + 12'(r)];
                    for (int c = 0; c < 8; c++) begin
                        if (row[7 - c]) begin
                            py = 5'(vy + 8'(r));
                            px = 6'(vx + 8'(c));
                            if (screen_shadow[{py, px}]) flag = 1'b1;
                            screen_shadow[{py, px}] ^= 1'b1;
                            drew = 1'b1;
                        end
                    end
                end
                vreg[15] = {7'd0, flag};
                pc_shadow = nxt;
            end
            4'hE: begin
                if (nn == 8'h9E) pc_shadow = keys[vx[3:0]] ? skp : nxt;
                else if (nn == 8'hA1) pc_shadow = keys[vx[3:0]] ? nxt : skp;
                else begin st = STAT_BADOP; pc_shadow = nxt; end
            end
            default: begin
                case (nn)
                    8'h07: begin vreg[x] = delay_shadow; pc_shadow = nxt; end
                    8'h0A: begin
                        if (keys == 16'd0) st = STAT_WAIT;
                        else begin
                            for (int i = 15; i >= 0; i--) if (keys[i]) vreg[x] = 8'(i);
                            pc_shadow = nxt;
                        end
                    end
                    8'h15: begin delay_shadow = vx; pc_shadow = nxt; end
                    8'h18: begin sound_shadow = vx; pc_shadow = nxt; end
                    8'h1E: begin index_shadow = index_shadow + {4'd0, vx}; pc_shadow = nxt; end
                    8'h29: begin index_shadow = 12'(vx[3:0]) * 12'd5; pc_shadow = nxt; end
                    8'h33: begin
                        mem_shadow[index_shadow]         = vx / 8'd100;
                        mem_shadow[index_shadow + 12'd1] = (vx / 8'd10) % 8'd10;
                        mem_shadow[index_shadow + 12'd2] = vx % 8'd10;
                        pc_shadow = nxt;
                    end
                    8'h55: begin
                        for (int i = 0; i <= x; i++) mem_shadow[index_shadow + 12'(i)] = vreg[i];
                        index_shadow = index_shadow + 12'(x) + 12'd1;
                        pc_shadow = nxt;
                    end
                    8'h65: begin
                        for (int i = 0; i <= x; i++) vreg[i] = mem_shadow[index_shadow + 12'(i)];
                        index_shadow = index_shadow + 12'(x) + 12'd1;
                        pc_shadow = nxt;
                    end
                    default: begin st = STAT_BADOP; pc_shadow = nxt; end
                endcase
            end
        endcase
        if (delay_shadow != 8'd0) delay_shadow--;
        if (sound_shadow != 8'd0) sound_shadow--;
    endtask

    task automatic predict_result(input logic [1:0] func, input logic [11:0] addr,
                                  input logic [7:0] wdata, input logic [15:0] keys,
                                  input logic [7:0] rnd);
        t_core_result r;
        logic [1:0] st;
        logic       drew;
        r = '0;
        st = STAT_OK;
        drew = 1'b0;
        case (func)
            FUNC_WR:  mem_shadow[addr] = wdata;
            FUNC_RD:  r.read_data = mem_shadow[addr];
            FUNC_PIX: r.read_data = {7'd0, screen_shadow[addr[10:0]]};
            default: begin
                execute_instruction(keys, rnd, st, drew);
                exec_count++;
                if (drew) draw_count++;
            end
        endcase
        r.program_counter = pc_shadow;
        r.index_value     = index_shadow;
        r.status          = st;
        r.drew            = drew;
        r.sound_on        = (sound_shadow != 8'd0);
        r.delay_value     = delay_shadow;
        pending_results.push_back(r);
    endtask

    // Valid is left high after acceptance; whoever does not send next lowers it.
    task automatic send_request(input logic [1:0] func, input logic [11:0] addr,
                                input logic [7:0] wdata, input logic [15:0] keys,
                                input logic [7:0] rnd);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {4'd0, rnd, keys, wdata, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        request_count++;
        predict_result(func, addr, wdata, keys, rnd);
    endtask

    task automatic pause_sender(input int n);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain_results();
        pause_sender(1);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Places one instruction at the program counter and executes it.
    task automatic run_op(input logic [15:0] op, input logic [15:0] keys = 16'd0,
                          input logic [7:0] rnd = 8'd0);
        logic [11:0] at;
        at = pc_shadow;
        send_request(FUNC_WR, at, op[15:8], 16'($urandom), 8'($urandom));
        send_request(FUNC_WR, at + 12'd1, op[7:0], 16'($urandom), 8'($urandom));
        send_request(FUNC_EXEC, 12'($urandom), 8'($urandom), keys, rnd);
    endtask

    function automatic logic [15:0] random_op();
        logic [15:0] op;
        op = 16'($urandom);
        case (op[15:12])
            4'h0: if ($urandom_range(0, 3) != 0) op = 16'h00EE;
            4'h8: if ($urandom_range(0, 7) != 0) begin
                op[3:0] = ($urandom_range(0, 8) == 8) ? 4'hE : 4'($urandom_range(0, 7));
            end
            4'hD: op[3:0] = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4));
            4'hE: if ($urandom_range(0, 7) != 0) op[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
            4'hF: begin
                case ($urandom_range(0, 9))
                    0: op[7:0] = 8'h07;
                    1: op[7:0] = 8'h0A;
                    2: op[7:0] = 8'h15;
                    3: op[7:0] = 8'h18;
                    4: op[7:0] = 8'h1E;
                    5: op[7:0] = 8'h29;
                    6: op[7:0] = 8'h33;
                    7: op[7:0] = 8'h55;
                    8: op[7:0] = 8'h65;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return op;
    endfunction

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_core_result want, got;
        if (m_axis_tvalid && m_axis_tready) begin
            got = t_core_result'(m_axis_tdata[43:0]);
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %0h", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("read_data", 12'(want.read_data), 12'(got.read_data));
                check_field("program_counter", want.program_counter, got.program_counter);
                check_field("index_value", want.index_value, got.index_value);
                check_field("status", 12'(want.status), 12'(got.status));
                check_field("drew", 12'(want.drew), 12'(got.drew));
                check_field("sound_on", 12'(want.sound_on), 12'(got.sound_on));
                check_field("delay_value", 12'(want.delay_value), 12'(got.delay_value));
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else if (rx_burst > 0) begin
            m_axis_tready <= 1'b0;
            rx_burst <= rx_burst - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            rx_burst <= $urandom_range(0, 4);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("chip8_instruction_core test failed");
            $finish;
        end
    end

    task automatic test_memory_port();
        send_request(FUNC_WR, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
        send_request(FUNC_RD, 12'hFFF, 8'h00, 16'h0000, 8'h00);
        send_request(FUNC_RD, 12'h000, 8'h00, 16'h0000, 8'h00);
        send_request(FUNC_PIX, 12'hFFF, 8'h00, 16'h0000, 8'h00);
        send_request(FUNC_PIX, 12'h000, 8'h00, 16'h0000, 8'h00);
    endtask

    task automatic test_alu();
        run_op(16'h60FF);
        run_op(16'h6101);
        run_op(16'h8014);             // carry out
        run_op(16'h8015);             // borrow
        run_op(16'h8017);
        run_op(16'h800E);
        run_op(16'h8006);
        run_op(16'h6FF0);
        run_op(16'h8F14);             // flag overwrites the result in VF
        run_op(16'h70FF);
        for (int s = 0; s < 4; s++) run_op(16'h8010 | 16'(s));
        run_op(16'h8018);             // undefined ALU subcode
        run_op(16'hC3FF, 16'd0, 8'hA5);
    endtask

    task automatic test_flow();
        run_op(16'h3000 | 16'(vreg[0]));
        run_op(16'h4000 | 16'(vreg[0]));
        run_op(16'h5016);
        run_op(16'h9010);
        run_op(16'h1FFF);
        run_op(16'h6005);             // fetch wraps from the top of memory
        run_op(16'hB3FC);
        run_op(16'h0123);             // unknown opcode
        run_op(16'hE0FF);
        run_op(16'hF0FF);
        run_op(16'h1300);
    endtask

    task automatic test_stack();
        for (int i = 0; i < 17; i++) run_op(16'h2000 | 16'(pc_shadow + 12'd2));
        for (int i = 0; i < 17; i++) run_op(16'h00EE);
    endtask

    task automatic test_misc();
        run_op(16'hA123);
        run_op(16'h613C);
        run_op(16'h621E);
        run_op(16'hF11E);
        run_op(16'hF129);
        run_op(16'h60FF);
        run_op(16'hA400);
        run_op(16'hF033);
        run_op(16'hFF55);
        run_op(16'hA400);
        run_op(16'hFF65);
        run_op(16'hA000);
        run_op(16'h603C);
        run_op(16'h611E);
        run_op(16'hD01F);             // sprite wraps both edges
        run_op(16'hD015);             // redraw clears lit pixels
        send_request(FUNC_PIX, 12'(30 * 64 + 60), 8'd0, 16'd0, 8'd0);
        run_op(16'h600F);
        run_op(16'hE09E, 16'h8000);
        run_op(16'hE0A1, 16'h8000);
        run_op(16'hE09E, 16'h0000);
        run_op(16'hE0A1, 16'h0000);
        run_op(16'h6009);
        run_op(16'hF015);
        run_op(16'hF018);
        run_op(16'hF107);
        run_op(16'hF20A, 16'h0000);   // no key yet, waits
        run_op(16'hF20A, 16'h0400);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) begin
            if (!no_idle && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 5));
            case ($urandom_range(0, 9))
                0: send_request(FUNC_WR, 12'($urandom), 8'($urandom), 16'($urandom),
                                8'($urandom));
                1: send_request(FUNC_RD, 12'($urandom), 8'($urandom), 16'($urandom),
                                8'($urandom));
                2: send_request(FUNC_PIX, 12'($urandom), 8'($urandom), 16'($urandom),
                                8'($urandom));
                default: run_op(random_op(),
                                ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom),
                                8'($urandom));
            endcase
        end
    endtask

    task automatic test_backpressure();
        drain_results();
        rx_hold = 300;
        for (int i = 0; i < 12; i++) send_request(FUNC_RD, 12'($urandom), 8'd0, 16'd0, 8'd0);
        drain_results();
    endtask

    initial begin
        int settle;
        for (int i = 0; i < 4096; i++) mem_shadow[i] = (i < FONT_BYTES) ? FONT[i] : 8'h00;
        for (int i = 0; i < 16; i++) begin vreg[i] = 8'd0; stack_shadow[i] = 12'd0; end
        for (int i = 0; i < 2048; i++) screen_shadow[i] = 1'b0;
        stack_depth_now = 0;
        index_shadow = 12'd0;
        pc_shadow = PC_START;
        delay_shadow = 8'd0;
        sound_shadow = 8'd0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_memory_port();
        test_alu();
        test_flow();
        test_stack();
        test_misc();
        test_random(20);
        test_backpressure();
        test_random(15);
        no_idle = 1'b1;
        test_random(13);
        drain_results();

        settle = 0;
        while (settle < 400) begin
            @(posedge i_clk);
            settle++;
        end
        $display("Covered %0d requests, %0d instructions executed, %0d of them drew.",
                 request_count, exec_count, draw_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("chip8_instruction_core test passed");
        else
            $display("chip8_instruction_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/chip8c_pkg.sv
sv/chip8c_ram.sv
sv/chip8c_regs.sv
sv/chip8c_alu.sv
sv/chip8_instruction_core.sv
sim/tb_chip8_instruction_core.sv
